### hdl/e2lc_pkg.sv
package e2lc_pkg;

  localparam logic [11:0] BaseYear       = 12'd1970;
  localparam logic [7:0]  YearWalkLimit  = 8'd200;
  localparam logic [7:0]  MonthWalkLimit = 8'd12;
  localparam logic [7:0]  ZoneUnitsReset = 8'd0;
  localparam logic [11:0] ZoneUnitReset  = 12'd900;
  localparam int unsigned PcWidth        = 4;

  // Reciprocals rounded up, exact for the operand ranges they see:
  // seconds / 128 by 675 with a shift of 35, seconds of day / 16 by 225 with 21,
  // seconds of hour / 4 by 15 with 14, and day count plus three by 7 with 19.
  localparam logic [25:0] RecipDays = 26'd50903317;
  localparam logic [25:0] RecipHour = 26'd9321;
  localparam logic [25:0] RecipMin  = 26'd1093;
  localparam logic [25:0] RecipDow  = 26'd74899;

  typedef enum logic [0:0] {
    CFG_ZONE_OFFSET_UNITS = 1'b0,
    CFG_ZONE_UNIT_SECONDS = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [3:0] {
    OP_MUL,    // acc = zone offset in seconds
    OP_ADDE,   // acc = acc + epoch
    OP_QUO,    // quotient by reciprocal multiplication, also into the days, hour or minute field
    OP_REM,    // acc = acc - quotient * divisor
    OP_MOVR,   // copy remainder into a result field
    OP_LDDOW,  // acc = days + 3
    OP_YEAR,   // one year of the year walk, repeats while a full year remains and the walk limit is not reached
    OP_MONTH,  // one month of the month walk
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_DAYS,
    DST_HOUR,
    DST_MIN,
    DST_SEC,
    DST_DOW
  } dst_e;

  typedef struct packed {
    op_e        op;
    dst_e       dst;
  } uword_t;

  function automatic uword_t ucode(logic [PcWidth-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, dst: DST_NONE};
    case (pc)
      4'd0:    w = '{op: OP_MUL,   dst: DST_NONE};
      4'd1:    w = '{op: OP_ADDE,  dst: DST_NONE};
      4'd2:    w = '{op: OP_QUO,   dst: DST_DAYS};
      4'd3:    w = '{op: OP_REM,   dst: DST_DAYS};
      4'd4:    w = '{op: OP_QUO,   dst: DST_HOUR};
      4'd5:    w = '{op: OP_REM,   dst: DST_HOUR};
      4'd6:    w = '{op: OP_QUO,   dst: DST_MIN};
      4'd7:    w = '{op: OP_REM,   dst: DST_MIN};
      4'd8:    w = '{op: OP_MOVR,  dst: DST_SEC};
      4'd9:    w = '{op: OP_LDDOW, dst: DST_NONE};
      4'd10:   w = '{op: OP_QUO,   dst: DST_DOW};
      4'd11:   w = '{op: OP_REM,   dst: DST_DOW};
      4'd12:   w = '{op: OP_MOVR,  dst: DST_DOW};
      4'd13:   w = '{op: OP_YEAR,  dst: DST_NONE};
      4'd14:   w = '{op: OP_MONTH, dst: DST_NONE};
      default: w = '{op: OP_DONE,  dst: DST_NONE};
    endcase
    return w;
  endfunction

  function automatic logic [16:0] divisor_of(dst_e dst);
    logic [16:0] d;
    case (dst)
      DST_DAYS: d = 17'd86400;
      DST_HOUR: d = 17'd3600;
      DST_MIN:  d = 17'd60;
      DST_DOW:  d = 17'd7;
      default:  d = 17'd1;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hdl/epoch_to_local_calendar.sv
// Converts UTC seconds since 1970 into local calendar fields. Pulse start while busy is low;
// the result appears for exactly one cycle with done_o high and cannot be held off, so the
// receiver must capture it then. One conversion keeps busy high through its final done step, and the
// result follows in the first cycle with busy low. The conversion is run by a microcoded
// sequencer: each division by the day, hour, minute or week length takes two steps, a
// reciprocal multiply for the quotient and a multiply and subtract for the remainder, and
// the year and month walks take one step per year or month.
// Configuration writes are taken at any time but are meant for when busy is low.
module epoch_to_local_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  day_of_week_o
);
  import e2lc_pkg::*;

  logic [7:0]  zone_units_q;
  logic [11:0] zone_unit_q;

  state_e              state_q, state_d;
  logic [PcWidth-1:0]  pc_q, pc_d;
  logic [7:0]          cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [31:0] epoch_q, epoch_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] days_q, days_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [2:0]  dow_q, dow_d;

  uword_t       uw;
  logic [24:0]  mul_a;
  logic [25:0]  mul_b;
  logic [50:0]  mul_p;
  logic [15:0]  quo_est;
  logic         leap;
  logic [8:0]   ylen;
  logic [4:0]   mlen;
  logic [20:0]  prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_units_q <= ZoneUnitsReset;
      zone_unit_q  <= ZoneUnitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ZONE_OFFSET_UNITS: zone_units_q <= cfg_wdata_i[7:0];
        CFG_ZONE_UNIT_SECONDS: zone_unit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    epoch_q  <= epoch_d;
    acc_q    <= acc_d;
    quo_q    <= quo_d;
    days_q   <= days_d;
    year_q   <= year_d;
    month_q  <= month_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    dow_q    <= dow_d;
  end

  assign uw       = ucode(pc_q);
  assign leap     = (year_q[1:0] == 2'b00);
  assign ylen     = leap ? 9'd366 : 9'd365;
  assign mlen     = month_len(month_q, leap);
  // Signed units times unsigned unit size; the product fits in 21 bits.
  assign prod     = $signed({{13{zone_units_q[7]}}, zone_units_q}) *
                    $signed({9'd0, zone_unit_q});

  // The shared multiplier forms the reciprocal product on a quotient step and
  // quotient times divisor on a remainder step.
  always_comb begin
    mul_a = {9'd0, quo_q};
    mul_b = {9'd0, divisor_of(uw.dst)};
    if (uw.op == OP_QUO) begin
      case (uw.dst)
        DST_DAYS: begin
          mul_a = acc_q[31:7];
          mul_b = RecipDays;
        end
        DST_HOUR: begin
          mul_a = {12'd0, acc_q[16:4]};
          mul_b = RecipHour;
        end
        DST_MIN: begin
          mul_a = {15'd0, acc_q[11:2]};
          mul_b = RecipMin;
        end
        DST_DOW: begin
          mul_a = {9'd0, acc_q[15:0]};
          mul_b = RecipDow;
        end
        default: ;
      endcase
    end
  end

  assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

  always_comb begin
    case (uw.dst)
      DST_DAYS: quo_est = mul_p[50:35];
      DST_HOUR: quo_est = mul_p[36:21];
      DST_MIN:  quo_est = mul_p[29:14];
      DST_DOW:  quo_est = mul_p[34:19];
      default:  quo_est = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    epoch_d  = epoch_q;
    acc_d    = acc_q;
    quo_d    = quo_q;
    days_d   = days_q;
    year_d   = year_q;
    month_d  = month_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    dow_d    = dow_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          epoch_d = epoch_seconds_i;
          year_d  = BaseYear;
          month_d = 4'd1;
          pc_d    = '0;
          cnt_d   = '0;
          quo_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        case (uw.op)
          OP_MUL: begin
            acc_d = {{11{prod[20]}}, prod};
            pc_d  = pc_q + 1'b1;
          end
          OP_ADDE: begin
            acc_d = acc_q + epoch_q;
            pc_d  = pc_q + 1'b1;
          end
          OP_QUO: begin
            quo_d = quo_est;
            case (uw.dst)
              DST_DAYS: days_d   = quo_est;
              DST_HOUR: hour_d   = quo_est[4:0];
              DST_MIN:  minute_d = quo_est[5:0];
              default: ;
            endcase
            pc_d = pc_q + 1'b1;
          end
          OP_REM: begin
            acc_d = acc_q - mul_p[31:0];
            pc_d  = pc_q + 1'b1;
          end
          OP_MOVR: begin
            case (uw.dst)
              DST_SEC: second_d = acc_q[5:0];
              DST_DOW: dow_d    = acc_q[2:0];
              default: ;
            endcase
            pc_d = pc_q + 1'b1;
          end
          OP_LDDOW: begin
            acc_d = {16'd0, days_q} + 32'd3;
            pc_d  = pc_q + 1'b1;
          end
          OP_YEAR: begin
            if (days_q >= {7'd0, ylen} && cnt_q < YearWalkLimit) begin
              days_d = days_q - {7'd0, ylen};
              year_d = year_q + 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              cnt_d = '0;
              pc_d  = pc_q + 1'b1;
            end
          end
          OP_MONTH: begin
            if (days_q >= {11'd0, mlen} && cnt_q < MonthWalkLimit) begin
              days_d  = days_q - {11'd0, mlen};
              month_d = month_q + 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end else begin
              cnt_d = '0;
              pc_d  = pc_q + 1'b1;
            end
          end
          OP_DONE: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_q == ST_RUN);
  assign done_o        = done_q;
  assign year_o        = year_q;
  assign month_o       = month_q;
  assign day_o         = 5'(days_q + 16'd1);
  assign hour_o        = hour_q;
  assign minute_o      = minute_q;
  assign second_o      = second_q;
  assign day_of_week_o = dow_q;

endmodule
